FILE: rtl/eipe_pkg.sv
// ----------------------------------------------------------------------------
// eipe_pkg
// Shared widths, constants and controller/datapath types for the
// energy index power estimator.
// ----------------------------------------------------------------------------
package eipe_pkg;

  localparam int RING_DEPTH_DEF = 10;

  localparam int TIME_W   = 32;
  localparam int ENERGY_W = 31;
  localparam int WINDOW_W = 4;
  localparam int POWER_W  = 31;
  localparam int HOUR_W   = 12;

  localparam logic [HOUR_W-1:0] SEC_PER_HOUR = 12'd3600;

  localparam int PROD_W    = ENERGY_W + HOUR_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [POWER_W-1:0] POWER_MAX = '1;

  typedef struct packed {
    logic accept;
    logic read;
    logic calc;
    logic mul;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_win;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/eipe_in_if.sv
// ----------------------------------------------------------------------------
// eipe_in_if
// Reading channel: one beat carries a timestamp and an energy index.
// ----------------------------------------------------------------------------
interface eipe_in_if;
  import eipe_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   timestamp;
  logic [ENERGY_W-1:0] energy_index;

  modport source (output valid, output timestamp, output energy_index, input ready);
  modport sink   (input valid, input timestamp, input energy_index, output ready);

endinterface

FILE: rtl/eipe_out_if.sv
// ----------------------------------------------------------------------------
// eipe_out_if
// Result channel: one beat carries one window estimate.
// ----------------------------------------------------------------------------
interface eipe_out_if;
  import eipe_pkg::*;

  logic                valid;
  logic                ready;
  logic [WINDOW_W-1:0] window;
  logic [POWER_W-1:0]  power;
  logic                available;
  logic                last_of_run;

  modport source (output valid, output window, output power, output available,
                  output last_of_run, input ready);
  modport sink   (input valid, input window, input power, input available,
                  input last_of_run, output ready);

endinterface

FILE: rtl/energy_index_power_estimator.sv
// ----------------------------------------------------------------------------
// energy_index_power_estimator
// Each window is processed in turn: read, difference, multiply, 43 division
// steps and load. A new reading is accepted only once all nine windows of the
// previous reading are done; the serial divider, one quotient bit per cycle, is
// shared by all windows.
// Reset: synchronous; ring entries read as zero through per-slot valid bits.
// ----------------------------------------------------------------------------
module energy_index_power_estimator #(
  parameter int RING_DEPTH = eipe_pkg::RING_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  eipe_in_if.sink    reading,
  eipe_out_if.source result
);
  import eipe_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  eipe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(reading.valid),
    .in_ready(reading.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  eipe_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_timestamp (reading.timestamp),
    .in_energy    (reading.energy_index),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_window   (result.window),
    .out_power    (result.power),
    .out_available(result.available),
    .out_last     (result.last_of_run)
  );

endmodule

FILE: rtl/eipe_ram.sv
// ----------------------------------------------------------------------------
// eipe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module eipe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/eipe_dp.sv
// ----------------------------------------------------------------------------
// eipe_dp
// Datapath: point ring, window differences, multiply by 3600, serial
// restoring divider and output register.
// ----------------------------------------------------------------------------
module eipe_dp #(
  parameter int RING_DEPTH = eipe_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  eipe_pkg::dp_cmd_t             cmd,
  output eipe_pkg::dp_sts_t             sts,
  input  logic [eipe_pkg::TIME_W-1:0]   in_timestamp,
  input  logic [eipe_pkg::ENERGY_W-1:0] in_energy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [eipe_pkg::WINDOW_W-1:0] out_window,
  output logic [eipe_pkg::POWER_W-1:0]  out_power,
  output logic                          out_available,
  output logic                          out_last
);
  import eipe_pkg::*;

  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int POINT_W = TIME_W + ENERGY_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(RING_DEPTH);

  logic [SLOT_W-1:0]     newest_slot;
  logic [TIME_W-1:0]     newest_time;
  logic [ENERGY_W-1:0]   newest_energy;
  logic [RING_DEPTH-1:0] valid;
  logic [SLOT_W-1:0]     win;
  logic                  rd_valid;
  logic [POINT_W-1:0]    rd_data;
  logic                  bad;
  logic                  neg;
  logic [ENERGY_W-1:0]   abs_e;
  logic [TIME_W-1:0]     abs_d;
  logic [PROD_W-1:0]     num;
  logic [TIME_W-1:0]     rem;

  logic                  push;
  logic [SLOT_W-1:0]     push_slot;
  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W-1:0]     rd_addr;
  logic [TIME_W-1:0]     old_time;
  logic [ENERGY_W-1:0]   old_energy;
  logic [ENERGY_W:0]     diff_e;
  logic [TIME_W:0]       diff_d;
  logic                  empty;
  logic [PROD_W-1:0]     prod;
  logic [TIME_W:0]       shifted;
  logic                  ge;
  logic                  over;
  logic                  ok;
  logic [POWER_W-1:0]    pw;

  assign push      = cmd.accept && (in_energy != newest_energy);
  assign push_slot = (newest_slot == '0) ? LAST_SLOT : newest_slot - 1'b1;
  assign slot_sum  = {1'b0, newest_slot} + {1'b0, win};
  assign rd_addr   = (slot_sum >= DEPTH_EXT) ? SLOT_W'(slot_sum - DEPTH_EXT)
                                             : slot_sum[SLOT_W-1:0];

  eipe_ram #(
    .WIDTH(POINT_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (push),
    .waddr(push_slot),
    .wdata({in_timestamp, in_energy}),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign old_time   = rd_valid ? rd_data[ENERGY_W +: TIME_W] : '0;
  assign old_energy = rd_valid ? rd_data[ENERGY_W-1:0] : '0;
  assign diff_e     = {1'b0, old_energy} - {1'b0, newest_energy};
  assign diff_d     = {1'b0, old_time} - {1'b0, newest_time};
  assign empty      = (old_time == '0) || (old_energy == '0) ||
                      (newest_time == '0) || (newest_energy == '0);

  assign prod = abs_e * SEC_PER_HOUR;

  assign shifted = {rem, num[PROD_W-1]};
  assign ge      = shifted >= {1'b0, abs_d};

  assign over = |num[PROD_W-1:POWER_W];
  assign ok   = !bad && !(neg && (num != '0));
  assign pw   = !ok ? '0 : (over ? POWER_MAX : num[POWER_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot   <= '0;
      newest_time   <= '0;
      newest_energy <= '0;
      valid         <= '0;
      win           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (push) begin
        newest_slot      <= push_slot;
        newest_time      <= in_timestamp;
        newest_energy    <= in_energy;
        valid[push_slot] <= 1'b1;
      end
      if (cmd.accept) begin
        win <= SLOT_W'(1);
      end else if (cmd.load_out) begin
        win <= win + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_valid <= valid[rd_addr];
    end
    if (cmd.calc) begin
      bad   <= empty || (diff_d == '0);
      neg   <= diff_e[ENERGY_W] ^ diff_d[TIME_W];
      abs_e <= diff_e[ENERGY_W] ? ENERGY_W'(~diff_e + 1'b1) : diff_e[ENERGY_W-1:0];
      abs_d <= diff_d[TIME_W] ? TIME_W'(~diff_d + 1'b1) : diff_d[TIME_W-1:0];
    end
    if (cmd.mul) begin
      num <= prod;
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? TIME_W'(shifted - {1'b0, abs_d}) : shifted[TIME_W-1:0];
      num <= {num[PROD_W-2:0], ge};
    end
    if (cmd.load_out) begin
      out_window    <= WINDOW_W'(win);
      out_power     <= pw;
      out_available <= ok;
      out_last      <= (win == LAST_SLOT);
    end
  end

  assign sts.last_win = (win == LAST_SLOT);
  assign sts.out_free = !out_valid || out_ready;

  a_unavail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_available |-> out_power == '0)
    else $error("unavailable result with nonzero power");

  a_push_updates: assert property (@(posedge clk) disable iff (rst)
    push |=> (newest_energy == $past(in_energy)) && valid[newest_slot])
    else $error("push did not update newest point");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_power) && $stable(out_window))
    else $error("result beat changed while stalled");

endmodule

FILE: rtl/eipe_ctrl.sv
// ----------------------------------------------------------------------------
// eipe_ctrl
// Controller: sequences read, difference, multiply, division steps and
// output load for each window of a reading.
// ----------------------------------------------------------------------------
module eipe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  eipe_pkg::dp_sts_t sts,
  output eipe_pkg::dp_cmd_t cmd
);
  import eipe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;

  assign in_ready     = (state == S_IDLE);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.read     = (state == S_READ);
  assign cmd.calc     = (state == S_CALC);
  assign cmd.mul      = (state == S_MUL);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.load_out = (state == S_OUT) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: state_next = S_CALC;
      S_CALC: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV: begin
        if (step == LAST_STEP) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_next = sts.last_win ? S_IDLE : S_READ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) begin
        step <= '0;
      end else if (state == S_DIV) begin
        step <= step + 1'b1;
      end
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> step <= LAST_STEP)
    else $error("division step count out of range");

  a_next_window: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && !sts.last_win |=> state == S_READ)
    else $error("window sequence did not continue");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_DIV && step == '0)
    else $error("division did not start from step zero");

endmodule
